@@ rtl/rbsi_pkg.sv @@
// rbsi_pkg: shared types and constants for the ray/box slab intersection block.
// No dependencies; used by rbsi_div, rbsi_lane and ray_box_slab_intersect.
`default_nettype none

package rbsi_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned THR_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd6;

    // divider: one prep stage, one stage per quotient bit, one saturate stage
    localparam int unsigned Q_BITS   = 32;
    localparam int unsigned DIV_LAT  = Q_BITS + 2;
    // lane: input stage, divider, ordering stage
    localparam int unsigned LANE_LAT = DIV_LAT + 2;

    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] direction_x;
        logic signed [31:0] direction_y;
        logic signed [31:0] direction_z;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] entry_distance;
        logic signed [31:0] exit_distance;
    } out_item_t;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic               skip;     // parallel axis, no narrowing
        logic               outside;  // parallel axis with origin outside slab
        logic signed [31:0] t_near;
        logic signed [31:0] t_far;
    } lane_res_t;

endpackage

`default_nettype wire

@@ rtl/ray_box_slab_intersect.sv @@
// ray_box_slab_intersect: top level, config registers, three axis lanes, merge stage.
// Depends on rbsi_pkg, rbsi_lane (and through it rbsi_div).
`default_nettype none

// Tests each ray against the configured axis-aligned box with the slab method,
// in signed fixed point with FRAC_BITS fraction bits. One ray is taken per
// cycle unless the output stalls. Each ray passes the lane input stage, the
// per-axis restoring dividers (one quotient bit per pipeline stage), the
// ordering stage and the output register. The whole pipeline advances when
// the output register is empty or being taken, so a stall at the output holds
// every stage. Configuration may only be written while the block is idle.
module ray_box_slab_intersect #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [rbsi_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire rbsi_pkg::in_item_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output rbsi_pkg::out_item_t                out_data
);

    localparam int unsigned LL = rbsi_pkg::LANE_LAT;

    logic signed [31:0] box_lo_reg [0:2];
    logic signed [31:0] box_hi_reg [0:2];
    logic [rbsi_pkg::THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < 3; n++)
            begin
                box_lo_reg[n] <= 32'sd0;
                box_hi_reg[n] <= 32'sd65536;
            end
            thr_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rbsi_pkg::CFG_BOX_MIN_X: box_lo_reg[0] <= cfg_wdata;
                rbsi_pkg::CFG_BOX_MAX_X: box_hi_reg[0] <= cfg_wdata;
                rbsi_pkg::CFG_BOX_MIN_Y: box_lo_reg[1] <= cfg_wdata;
                rbsi_pkg::CFG_BOX_MAX_Y: box_hi_reg[1] <= cfg_wdata;
                rbsi_pkg::CFG_BOX_MIN_Z: box_lo_reg[2] <= cfg_wdata;
                rbsi_pkg::CFG_BOX_MAX_Z: box_hi_reg[2] <= cfg_wdata;
                rbsi_pkg::CFG_THRESHOLD: thr_reg <= cfg_wdata[rbsi_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [LL-1:0] vld_reg;
    logic out_valid_reg;
    rbsi_pkg::out_item_t out_data_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    logic signed [31:0] org [0:2];
    logic signed [31:0] dir [0:2];
    rbsi_pkg::lane_res_t lres [0:2];

    assign org[0] = in_data.origin_x;
    assign org[1] = in_data.origin_y;
    assign org[2] = in_data.origin_z;
    assign dir[0] = in_data.direction_x;
    assign dir[1] = in_data.direction_y;
    assign dir[2] = in_data.direction_z;

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clk (clk),
            .en  (en),
            .org (org[a]),
            .dir (dir[a]),
            .lo  (box_lo_reg[a]),
            .hi  (box_hi_reg[a]),
            .thr (thr_reg),
            .res (lres[a])
        );
    end

    // merge: widest entry, narrowest exit over the non-parallel axes
    rbsi_pkg::out_item_t merged;
    logic                miss;

    always_comb
    begin
        merged.entry_distance = rbsi_pkg::T_MIN;
        merged.exit_distance  = rbsi_pkg::T_MAX;
        miss = 1'b0;
        for (int n = 0; n < 3; n++)
        begin
            if (lres[n].skip)
                miss = miss | lres[n].outside;
            else
            begin
                if (lres[n].t_near > merged.entry_distance)
                    merged.entry_distance = lres[n].t_near;
                if (lres[n].t_far < merged.exit_distance)
                    merged.exit_distance = lres[n].t_far;
            end
        end
        merged.hit = !miss && (merged.entry_distance <= merged.exit_distance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LL-2:0], in_valid};
            out_valid_reg <= vld_reg[LL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= merged;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.hit |->
            out_data_reg.entry_distance <= out_data_reg.exit_distance)
        else $error("hit reported with entry beyond exit");

    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(vld_reg[LL-1]))
        else $error("result without a transfer in the pipeline");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(vld_reg))
        else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

@@ rtl/rbsi_div.sv @@
// rbsi_div: pipelined signed divider, (num) / (den), truncating, saturated to 32 bits.
// One quotient bit per stage. Depends on rbsi_pkg.
`default_nettype none

module rbsi_div #(
    parameter int unsigned NUM_W = 49
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic signed [31:0]      den,
    output logic signed [31:0]           quot
);

    localparam int unsigned QB   = rbsi_pkg::Q_BITS;
    localparam int unsigned HI_W = NUM_W - QB;
    localparam int unsigned CW   = (HI_W > QB) ? HI_W : QB;

    logic [QB-1:0] rem_reg [0:QB];
    logic [QB-1:0] low_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic [QB-1:0] d_reg   [0:QB];
    logic          neg_reg [0:QB];
    logic          zero_reg[0:QB];
    logic          ovf_reg [0:QB];
    logic signed [31:0] quot_reg;

    logic [NUM_W-1:0] nmag;
    logic [QB-1:0]    dmag;
    logic [CW-1:0]    hi_ext;
    logic             ovf_next;

    always_comb
    begin
        nmag     = num[NUM_W-1] ? (NUM_W'(0) - num) : num;
        dmag     = den[31] ? (QB'(0) - den) : den;
        hi_ext   = CW'(nmag[NUM_W-1:QB]);
        ovf_next = (hi_ext >= CW'(dmag));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= ovf_next ? '0 : hi_ext[QB-1:0];
            low_reg[0]  <= nmag[QB-1:0];
            q_reg[0]    <= '0;
            d_reg[0]    <= dmag;
            neg_reg[0]  <= (den == '0) ? num[NUM_W-1] : (num[NUM_W-1] ^ den[31]);
            zero_reg[0] <= (num == '0);
            ovf_reg[0]  <= ovf_next;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_bit
        logic [QB:0] trial;
        logic [QB:0] diff;
        logic        ge;

        always_comb
        begin
            trial = {rem_reg[k], low_reg[k][QB-1]};
            diff  = trial - {1'b0, d_reg[k]};
            ge    = (trial >= {1'b0, d_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? diff[QB-1:0] : trial[QB-1:0];
                low_reg[k+1]  <= {low_reg[k][QB-2:0], 1'b0};
                q_reg[k+1]    <= {q_reg[k][QB-2:0], ge};
                d_reg[k+1]    <= d_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end
    end

    logic [QB-1:0]      qf;
    logic signed [31:0] sat_next;

    always_comb
    begin
        qf = q_reg[QB];
        if (zero_reg[QB])
            sat_next = '0;
        else if (ovf_reg[QB])
            sat_next = neg_reg[QB] ? rbsi_pkg::T_MIN : rbsi_pkg::T_MAX;
        else if (!neg_reg[QB])
            sat_next = qf[QB-1] ? rbsi_pkg::T_MAX : $signed(qf);
        else
            sat_next = (qf > 32'h8000_0000) ? rbsi_pkg::T_MIN : $signed(QB'(0) - qf);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quot_reg <= sat_next;
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

@@ rtl/rbsi_lane.sv @@
// rbsi_lane: one axis of the slab test: plane distances, parallel check, ordering.
// Depends on rbsi_pkg and rbsi_div.
`default_nettype none

module rbsi_lane #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic signed [31:0]    org,
    input  wire logic signed [31:0]    dir,
    input  wire logic signed [31:0]    lo,
    input  wire logic signed [31:0]    hi,
    input  wire logic [rbsi_pkg::THR_W-1:0] thr,
    output rbsi_pkg::lane_res_t        res
);

    localparam int unsigned NUM_W = 33 + FRAC_BITS;
    localparam int unsigned DL    = rbsi_pkg::DIV_LAT;

    logic signed [NUM_W-1:0] num_lo_reg;
    logic signed [NUM_W-1:0] num_hi_reg;
    logic signed [31:0]      dir_reg;
    logic                    par_reg [0:DL];
    logic                    out_reg [0:DL];
    rbsi_pkg::lane_res_t     res_reg;

    logic signed [32:0] d_lo;
    logic signed [32:0] d_hi;
    logic [32:0]        mag;

    always_comb
    begin
        d_lo = 33'(lo) - 33'(org);
        d_hi = 33'(hi) - 33'(org);
        mag  = dir[31] ? (33'd0 - 33'(dir)) : 33'(dir);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_lo_reg <= {d_lo, {FRAC_BITS{1'b0}}};
            num_hi_reg <= {d_hi, {FRAC_BITS{1'b0}}};
            dir_reg    <= dir;
            par_reg[0] <= (mag < 33'(thr));
            out_reg[0] <= (org < lo) || (org > hi);
        end
    end

    for (genvar k = 0; k < DL; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                par_reg[k+1] <= par_reg[k];
                out_reg[k+1] <= out_reg[k];
            end
        end
    end

    logic signed [31:0] ta;
    logic signed [31:0] tb;

    rbsi_div #(.NUM_W(NUM_W)) u_div_lo (
        .clk  (clk),
        .en   (en),
        .num  (num_lo_reg),
        .den  (dir_reg),
        .quot (ta)
    );

    rbsi_div #(.NUM_W(NUM_W)) u_div_hi (
        .clk  (clk),
        .en   (en),
        .num  (num_hi_reg),
        .den  (dir_reg),
        .quot (tb)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.skip    <= par_reg[DL];
            res_reg.outside <= par_reg[DL] && out_reg[DL];
            res_reg.t_near  <= (ta > tb) ? tb : ta;
            res_reg.t_far   <= (ta > tb) ? ta : tb;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire
